[rtl/core/rvf_pkg.sv]
// rvf_pkg: shared widths, register codes and reset values of the radial vignette factor unit.
// Used by the channel interfaces and the top level; depends on nothing.
package rvf_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int DIM_BITS       = 13;
	localparam int INV_BITS       = 32;
	localparam int COEF_BITS      = 20;
	localparam int RADIUS_BITS    = 18;
	localparam int OUT_BITS       = 22;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_INV_MAX_R2   = 3'd2,
		REG_COEF_QUAD    = 3'd3,
		REG_COEF_QUART   = 3'd4,
		REG_COEF_SEXT    = 3'd5
	} cfg_reg_t;

	localparam logic [DIM_BITS-1:0]  WIDTH_RST  = 13'd640;
	localparam logic [DIM_BITS-1:0]  HEIGHT_RST = 13'd480;
	localparam logic [INV_BITS-1:0]  INV_RST    = 32'd26844;
	localparam logic [COEF_BITS-1:0] COEF_RST   = 20'd0;

endpackage

[rtl/core/rvf_if.sv]
// rvf_if: valid/ready channels of the radial vignette factor unit (pixel items in, gain items out).
// Depends on rvf_pkg for field widths.
interface rvf_pixel_if #(
	parameter int COORD_BITS = rvf_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [COORD_BITS-1:0]             pixel_x;
	logic [COORD_BITS-1:0]             pixel_y;
	logic [rvf_pkg::RADIUS_BITS-1:0]   normalized_radius;

	modport source (output valid, opcode, pixel_x, pixel_y, normalized_radius, input ready);
	modport sink   (input valid, opcode, pixel_x, pixel_y, normalized_radius, output ready);
endinterface

interface rvf_gain_if;
	logic                                valid;
	logic                                ready;
	logic signed [rvf_pkg::OUT_BITS-1:0] vignette_factor;

	modport source (output valid, vignette_factor, input ready);
	modport sink   (input valid, vignette_factor, output ready);
endinterface

[rtl/core/radial_vignette_factor_unit.sv]
// radial_vignette_factor_unit: gain 1 + v1*r^2 + v2*r^4 + v3*r^6 per item, Horner form in r^2.
// Depends on rvf_pkg and the channel interfaces in rvf_if.sv.
// Eleven register stages. Throughput one item per clock while the gain channel is ready.
// The rate is set by the eleven-stage pipeline, which spreads the multiplies and wide adds over
// its stages; each stage holds its item under back-pressure and empty stages fill behind a stall.
// Reset clears every stage valid bit and loads the register reset values.
module radial_vignette_factor_unit #(
	parameter int COORD_BITS = rvf_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rvf_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rvf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rvf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	rvf_pixel_if.sink                            pixel,
	rvf_gain_if.source                           gain
);

	localparam int NSTAGE = 11;
	localparam int CB     = rvf_pkg::COEF_BITS;
	localparam int HDIM   = rvf_pkg::DIM_BITS - 1;
	localparam int DW     = ((COORD_BITS > HDIM) ? COORD_BITS : HDIM) + 1;
	localparam int SQW    = 2 * DW - 2;
	localparam int D2W    = 2 * DW - 1;
	localparam int SPLIT  = 16;
	localparam int HIW    = D2W - SPLIT;
	localparam int IW     = rvf_pkg::INV_BITS;
	localparam int PW     = D2W + IW + 1;
	localparam int RSQW   = 2 * rvf_pkg::RADIUS_BITS;
	localparam int RNDW   = RSQW + 1;
	localparam int R2W    = FRAC_BITS + 4;
	localparam int A1     = CB + 6;
	localparam int A2     = A1 + 6;
	localparam int A3     = A2 + 6;
	localparam int M1W    = CB + R2W + 1;
	localparam int M2W    = A1 + R2W + 1;
	localparam int M3W    = A2 + R2W + 1;
	localparam int OW     = rvf_pkg::OUT_BITS;

	localparam longint R2_MAX  = (longint'(1) << R2W) - 1;
	localparam longint HALF    = longint'(1) << (FRAC_BITS - 1);
	localparam longint PRND    = longint'(1) << (31 - FRAC_BITS);
	localparam longint ONE     = longint'(1) << FRAC_BITS;
	localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) << (OW - 1));

	// configuration registers
	logic [rvf_pkg::DIM_BITS-1:0] width_q, height_q;
	logic [IW-1:0]                inv_q;
	logic signed [CB-1:0]         coef_quad_q, coef_quart_q, coef_sext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= rvf_pkg::WIDTH_RST;
			height_q     <= rvf_pkg::HEIGHT_RST;
			inv_q        <= rvf_pkg::INV_RST;
			coef_quad_q  <= rvf_pkg::COEF_RST;
			coef_quart_q <= rvf_pkg::COEF_RST;
			coef_sext_q  <= rvf_pkg::COEF_RST;
		end else if (cfg_we) begin
			case (rvf_pkg::cfg_reg_t'(cfg_index))
				rvf_pkg::REG_IMAGE_WIDTH:  width_q      <= cfg_data[rvf_pkg::DIM_BITS-1:0];
				rvf_pkg::REG_IMAGE_HEIGHT: height_q     <= cfg_data[rvf_pkg::DIM_BITS-1:0];
				rvf_pkg::REG_INV_MAX_R2:   inv_q        <= cfg_data[IW-1:0];
				rvf_pkg::REG_COEF_QUAD:    coef_quad_q  <= cfg_data[CB-1:0];
				rvf_pkg::REG_COEF_QUART:   coef_quart_q <= cfg_data[CB-1:0];
				rvf_pkg::REG_COEF_SEXT:    coef_sext_q  <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when it is empty or its successor loads
	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;

	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || gain.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= pixel.valid;
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pixel.ready          = en[1];
	assign gain.valid           = vld_q[NSTAGE];

	// stage registers
	logic                             op_s1, op_s2, op_s3, op_s4;
	logic signed [DW-1:0]             dx_s1, dy_s1;
	logic [rvf_pkg::RADIUS_BITS-1:0]  r_s1;
	logic [SQW-1:0]                   sqx_s2, sqy_s2;
	logic [RSQW-1:0]                  rsq_s2;
	logic [D2W-1:0]                   d2_s3;
	logic [R2W-1:0]                   r2n_s3, r2n_s4, r2_s5;
	logic [R2W-1:0]                   r2_s6, r2_s7, r2_s8, r2_s9;
	logic [SPLIT+IW-1:0]              plo_s4;
	logic [HIW+IW-1:0]                phi_s4;
	logic signed [M1W-1:0]            m1_s6;
	logic signed [A1-1:0]             acc1_s7;
	logic signed [M2W-1:0]            m2_s8;
	logic signed [A2-1:0]             acc2_s9;
	logic signed [M3W-1:0]            m3_s10;
	logic signed [OW-1:0]             gain_s11;

	// combinational helpers
	logic signed [DW-1:0]  dx, dy;
	logic signed [2*DW-1:0] sqx_full, sqy_full;
	logic [RNDW-1:0]       rnd_r, rsh_r;
	logic [R2W-1:0]        r2n, r2p;
	logic [PW-1:0]         prod, psh;
	logic signed [M1W-1:0] rnd1, sh1;
	logic signed [M2W-1:0] rnd2, sh2;
	logic signed [M3W-1:0] rnd3, sh3;
	logic signed [A3-1:0]  acc3;
	logic signed [OW-1:0]  sat;

	always_comb begin
		dx = $signed({{(DW-COORD_BITS){1'b0}}, pixel.pixel_x})
			- $signed({{(DW-HDIM){1'b0}}, width_q[HDIM:1]});
		dy = $signed({{(DW-COORD_BITS){1'b0}}, pixel.pixel_y})
			- $signed({{(DW-HDIM){1'b0}}, height_q[HDIM:1]});

		sqx_full = dx_s1 * dx_s1;
		sqy_full = dy_s1 * dy_s1;

		// normalised radius squared, rounded half up, clamped below 16.0
		rnd_r = {1'b0, rsq_s2} + RNDW'(HALF);
		rsh_r = rnd_r >> FRAC_BITS;
		r2n   = (rsh_r > RNDW'(R2_MAX)) ? R2W'(R2_MAX) : rsh_r[R2W-1:0];

		// d2 * reciprocal from the two partial products, rounded, clamped
		prod = (PW'(phi_s4) << SPLIT) + PW'(plo_s4) + PW'(PRND);
		psh  = prod >> (32 - FRAC_BITS);
		r2p  = (psh > PW'(R2_MAX)) ? R2W'(R2_MAX) : psh[R2W-1:0];

		// Horner steps: floor((m + half) / 2^F) plus next coefficient
		rnd1 = m1_s6 + M1W'(HALF);
		sh1  = rnd1 >>> FRAC_BITS;
		rnd2 = m2_s8 + M2W'(HALF);
		sh2  = rnd2 >>> FRAC_BITS;
		rnd3 = m3_s10 + M3W'(HALF);
		sh3  = rnd3 >>> FRAC_BITS;
		acc3 = A3'($signed(sh3[A3-2:0])) + A3'(ONE);

		if (acc3 > A3'(OUT_MAX))      sat = OW'(OUT_MAX);
		else if (acc3 < A3'(OUT_MIN)) sat = OW'(OUT_MIN);
		else                          sat = acc3[OW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1 <= pixel.opcode;
			dx_s1 <= dx;
			dy_s1 <= dy;
			r_s1  <= pixel.normalized_radius;
		end
		if (en[2]) begin
			op_s2  <= op_s1;
			sqx_s2 <= sqx_full[SQW-1:0];
			sqy_s2 <= sqy_full[SQW-1:0];
			rsq_s2 <= r_s1 * r_s1;
		end
		if (en[3]) begin
			op_s3  <= op_s2;
			d2_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			r2n_s3 <= r2n;
		end
		if (en[4]) begin
			op_s4  <= op_s3;
			plo_s4 <= d2_s3[SPLIT-1:0] * inv_q;
			phi_s4 <= d2_s3[D2W-1:SPLIT] * inv_q;
			r2n_s4 <= r2n_s3;
		end
		if (en[5]) begin
			r2_s5 <= op_s4 ? r2n_s4 : r2p;
		end
		if (en[6]) begin
			m1_s6 <= coef_sext_q * $signed({1'b0, r2_s5});
		end
		if (en[7]) begin
			acc1_s7 <= A1'($signed(sh1[A1-2:0])) + A1'(coef_quart_q);
		end
		if (en[8]) begin
			m2_s8 <= acc1_s7 * $signed({1'b0, r2_s7});
		end
		if (en[9]) begin
			acc2_s9 <= A2'($signed(sh2[A2-2:0])) + A2'(coef_quad_q);
		end
		if (en[10]) begin
			m3_s10 <= acc2_s9 * $signed({1'b0, r2_s9});
		end
		if (en[11]) begin
			gain_s11 <= sat;
		end
	end

	assign gain.vignette_factor = gain_s11;

	// r^2 travels alongside the Horner stages
	always_ff @(posedge clk) begin
		if (en[6]) r2_s6 <= r2_s5;
		if (en[7]) r2_s7 <= r2_s6;
		if (en[8]) r2_s8 <= r2_s7;
		if (en[9]) r2_s9 <= r2_s8;
	end

	// a refused item means every stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n) !pixel.ready |-> (&vld_q))
		else $error("input stalled with an empty stage");

	assert property (@(posedge clk) disable iff (!arst_n) gain.ready |-> pixel.ready)
		else $error("input stalled while output drains");

	assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> vld_q[1])
		else $error("accepted item missing from first stage");

	assert property (@(posedge clk) disable iff (!arst_n) !pixel.ready |=> vld_q[NSTAGE])
		else $error("full pipeline lost its output item");

endmodule

[test/tb_radial_vignette_factor_unit.sv]
// Self-checking bench for radial_vignette_factor_unit: drives pixel and radius items,
// predicts each gain in fixed point and checks the gain channel item by item.
// Depends on rvf_pkg and the channel interfaces in rvf_if.sv.
module tb_radial_vignette_factor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rvf_pkg::*;

	localparam int COORD_W         = COORD_BITS_DEF;
	localparam int FRAC            = FRAC_BITS_DEF;
	localparam int LATENCY         = 11;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS     = 100;

	// indexes past the register list; writes there must change nothing
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam longint R2_CLAMP = (longint'(1) << (FRAC + 4)) - 1;
	localparam longint GAIN_HI  = (longint'(1) << (OUT_BITS - 1)) - 1;
	localparam longint GAIN_LO  = -(longint'(1) << (OUT_BITS - 1));

	typedef struct packed {
		logic                   opcode;
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic [RADIUS_BITS-1:0] radius;
	} pixel_item_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	logic                   drv_valid  = 1'b0;
	logic                   drv_opcode = 1'b0;
	logic [COORD_W-1:0]     drv_x      = '0;
	logic [COORD_W-1:0]     drv_y      = '0;
	logic [RADIUS_BITS-1:0] drv_radius = '0;
	logic                   drv_ready  = 1'b0;

	rvf_pixel_if #(.COORD_BITS(COORD_W)) pixel_ch ();
	rvf_gain_if gain_ch ();

	assign pixel_ch.valid             = drv_valid;
	assign pixel_ch.opcode            = drv_opcode;
	assign pixel_ch.pixel_x           = drv_x;
	assign pixel_ch.pixel_y           = drv_y;
	assign pixel_ch.normalized_radius = drv_radius;
	assign gain_ch.ready              = drv_ready;

	radial_vignette_factor_unit #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS (FRAC)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel_ch),
		.gain     (gain_ch)
	);

	// register copies used for prediction
	logic [DIM_BITS-1:0]         img_w = WIDTH_RST;
	logic [DIM_BITS-1:0]         img_h = HEIGHT_RST;
	logic [INV_BITS-1:0]         inv_r2 = INV_RST;
	logic signed [COEF_BITS-1:0] coef_v1 = COEF_RST;
	logic signed [COEF_BITS-1:0] coef_v2 = COEF_RST;
	logic signed [COEF_BITS-1:0] coef_v3 = COEF_RST;

	pixel_item_t                  pixel_pending[$];
	logic signed [OUT_BITS-1:0]   gain_expected[$];
	pixel_item_t                  next_item;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  hold_off_req   = 0;
	int  hold_off_seen  = 0;
	int  hold_off_left  = 0;
	int  quiet_cycles   = 0;
	int  mismatches     = 0;
	bit  pix_fire;
	bit  gain_fire;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round(a*b / 2^FRAC), ties towards plus infinity
	function automatic longint round_product(longint a, longint b);
		return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] predict_gain(pixel_item_t it);
		longint dx, dy, r2, acc;
		if (it.opcode == 1'b0) begin
			dx = longint'(it.x) - longint'(img_w >> 1);
			dy = longint'(it.y) - longint'(img_h >> 1);
			r2 = ((dx * dx + dy * dy) * longint'(inv_r2) + (longint'(1) << (31 - FRAC)))
				>> (32 - FRAC);
		end else begin
			r2 = (longint'(it.radius) * longint'(it.radius) + (longint'(1) << (FRAC - 1)))
				>> FRAC;
		end
		if (r2 > R2_CLAMP) r2 = R2_CLAMP;
		acc = longint'(coef_v3);
		acc = longint'(coef_v2) + round_product(acc, r2);
		acc = longint'(coef_v1) + round_product(acc, r2);
		acc = (longint'(1) << FRAC) + round_product(acc, r2);
		if (acc > GAIN_HI) acc = GAIN_HI;
		else if (acc < GAIN_LO) acc = GAIN_LO;
		return acc[OUT_BITS-1:0];
	endfunction

	// driver: holds an item until taken, otherwise offers the next one or idles
	always @(negedge clk) begin
		if (!drv_valid || pix_fire) begin
			if (pixel_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pixel_pending.pop_front();
				drv_valid  <= 1'b1;
				drv_opcode <= next_item.opcode;
				drv_x      <= next_item.x;
				drv_y      <= next_item.y;
				drv_radius <= next_item.radius;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_off_seen != hold_off_req) begin
			hold_off_seen <= hold_off_req;
			hold_off_left <= HOLD_OFF_CYCLES;
			drv_ready     <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			drv_ready     <= 1'b0;
		end else begin
			drv_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on every accepted input item, check every accepted gain item
	always @(posedge clk) begin
		logic signed [OUT_BITS-1:0] want;
		pix_fire  = pixel_ch.valid && pixel_ch.ready;
		gain_fire = gain_ch.valid && gain_ch.ready;
		if (pix_fire)
			gain_expected.push_back(predict_gain({pixel_ch.opcode, pixel_ch.pixel_x,
				pixel_ch.pixel_y, pixel_ch.normalized_radius}));
		if (gain_fire) begin
			if (gain_expected.size() == 0) begin
				$display("%0t: unexpected gain item, vignette_factor %0d", $time,
					gain_ch.vignette_factor);
				mismatches++;
			end else begin
				want = gain_expected.pop_front();
				if (gain_ch.vignette_factor !== want) begin
					$display("%0t: vignette_factor mismatch, expected %0d got %0d", $time,
						want, gain_ch.vignette_factor);
					mismatches++;
				end
			end
		end
		quiet_cycles = (pix_fire || gain_fire) ? 0 : quiet_cycles + 1;
	end

	initial begin
		do @(negedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_IMAGE_WIDTH:  img_w   = data[DIM_BITS-1:0];
			REG_IMAGE_HEIGHT: img_h   = data[DIM_BITS-1:0];
			REG_INV_MAX_R2:   inv_r2  = data[INV_BITS-1:0];
			REG_COEF_QUAD:    coef_v1 = data[COEF_BITS-1:0];
			REG_COEF_QUART:   coef_v2 = data[COEF_BITS-1:0];
			REG_COEF_SEXT:    coef_v3 = data[COEF_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// unused fields carry random junk
	task automatic queue_coord(input int unsigned x, input int unsigned y);
		pixel_item_t it;
		it.opcode = 1'b0;
		it.x      = x[COORD_W-1:0];
		it.y      = y[COORD_W-1:0];
		it.radius = RADIUS_BITS'($urandom);
		pixel_pending.push_back(it);
	endtask

	task automatic queue_radius(input int unsigned r);
		pixel_item_t it;
		it.opcode = 1'b1;
		it.x      = COORD_W'($urandom);
		it.y      = COORD_W'($urandom);
		it.radius = r[RADIUS_BITS-1:0];
		pixel_pending.push_back(it);
	endtask

	task automatic queue_random_item();
		int unsigned w, h;
		w = 32'(img_w);
		h = 32'(img_h);
		if ($urandom_range(1)) begin
			if ($urandom_range(3) == 0) queue_radius($urandom_range(0, 2**RADIUS_BITS - 1));
			else queue_radius($urandom_range(0, 2**(FRAC + 1)));
		end else if ($urandom_range(3) != 0 && w != 0 && w <= 4096 && h != 0 && h <= 4096) begin
			queue_coord($urandom_range(0, w - 1), $urandom_range(0, h - 1));
		end else begin
			queue_coord($urandom_range(0, 2**COORD_W - 1), $urandom_range(0, 2**COORD_W - 1));
		end
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] random_dim();
		case ($urandom_range(5))
			0:       return 1;
			1:       return 4096;
			2:       return $urandom;
			default: return $urandom_range(2, 4096);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] random_coef();
		case ($urandom_range(5))
			0:       return 32'h0007_FFFF;
			1:       return 32'h0008_0000;
			2:       return $urandom;
			default: return $urandom_range(0, 2**18) - 2**17;
		endcase
	endfunction

	task automatic random_setting();
		int unsigned cx, cy;
		write_reg(REG_IMAGE_WIDTH, random_dim());
		write_reg(REG_IMAGE_HEIGHT, random_dim());
		cx = 32'(img_w >> 1);
		cy = 32'(img_h >> 1);
		// mostly a reciprocal that matches the image corner, sometimes anything
		if ($urandom_range(3) == 0) write_reg(REG_INV_MAX_R2, $urandom);
		else write_reg(REG_INV_MAX_R2, 32'hFFFF_FFFF / (cx * cx + cy * cy + 1));
		write_reg(REG_COEF_QUAD, random_coef());
		write_reg(REG_COEF_QUART, random_coef());
		write_reg(REG_COEF_SEXT, random_coef());
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
	endtask

	// checked at the rising edge, where the driver's outputs are settled
	task automatic drain();
		while (pixel_pending.size() != 0 || drv_valid || gain_expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: zero coefficients give unity gain everywhere
		queue_coord(0, 0);
		queue_radius(2**RADIUS_BITS - 1);
		drain();

		write_reg(REG_IMAGE_WIDTH, 640);
		write_reg(REG_IMAGE_HEIGHT, 480);
		write_reg(REG_INV_MAX_R2, 26844);
		write_reg(REG_COEF_QUAD, -26214);
		write_reg(REG_COEF_QUART, 13107);
		write_reg(REG_COEF_SEXT, -3277);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		queue_coord(320, 240);
		queue_coord(319, 240);
		queue_coord(0, 0);
		queue_coord(639, 479);
		queue_coord(4095, 0);
		queue_coord(0, 4095);
		queue_coord(4095, 4095);
		queue_coord(12'hAAA, 12'h555);
		queue_coord(12'h555, 12'hAAA);
		queue_radius(0);
		queue_radius(1);
		queue_radius(2**FRAC);
		queue_radius(18'h2AAAA);
		queue_radius(18'h15555);
		queue_radius(2**RADIUS_BITS - 1);
		drain();

		// zero width, widest height, largest reciprocal, top coefficients: saturates high for large radii
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF);
		write_reg(REG_INV_MAX_R2, 32'hFFFF_FFFF);
		write_reg(REG_COEF_QUAD, 32'h0007_FFFF);
		write_reg(REG_COEF_QUART, 32'h0007_FFFF);
		write_reg(REG_COEF_SEXT, 32'h0007_FFFF);
		queue_coord(0, 0);
		queue_coord(4095, 4095);
		queue_radius(2**RADIUS_BITS - 1);
		queue_radius(0);
		drain();

		// zero reciprocal, bottom coefficients: saturates low for large radii
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 1);
		write_reg(REG_INV_MAX_R2, 0);
		write_reg(REG_COEF_QUAD, 32'hFFF8_0000);
		write_reg(REG_COEF_QUART, 32'h0008_0000);
		write_reg(REG_COEF_SEXT, 32'h0008_0000);
		queue_coord(4095, 4095);
		queue_coord(0, 0);
		queue_radius(2**FRAC);
		queue_radius(2**RADIUS_BITS - 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			random_setting();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			repeat (PHASE_ITEMS) queue_random_item();
			drain();
		end

		// long receiver hold-off with the sender flat out, so the pipeline backs up
		random_setting();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req++;
		repeat (PHASE_ITEMS) queue_random_item();
		drain();

		repeat (LATENCY * 3) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
